/* rtl/rbc_pkg.sv */
// Shared types and constants of the retry/backoff controller.
// No dependencies; every other file refers to it by scoped names.
package rbc_pkg;

    localparam int STATUS_W   = 10;
    localparam int DELAY_W    = 16;
    localparam int WAIT_W     = 25;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    localparam int DEF_BASE_DELAY_MS = 100;
    localparam int DEF_MAX_SHIFT     = 12;

    localparam logic [WAIT_W-1:0] LONG_WAIT_MS = WAIT_W'(600000);
    localparam logic [WAIT_W-1:0] WAIT_MAX     = '1;
    localparam logic [9:0]        MS_PER_S     = 10'd1000;

    localparam logic [STATUS_W-1:0] ST_NONE         = 10'd0;
    localparam logic [STATUS_W-1:0] ST_SUCCESS_LO   = 10'd200;
    localparam logic [STATUS_W-1:0] ST_SUCCESS_HI   = 10'd299;
    localparam logic [STATUS_W-1:0] ST_NOT_MODIFIED = 10'd304;
    localparam logic [STATUS_W-1:0] ST_CLIENT_LO    = 10'd400;
    localparam logic [STATUS_W-1:0] ST_REQ_TIMEOUT  = 10'd408;
    localparam logic [STATUS_W-1:0] ST_SERVER_LO    = 10'd500;
    localparam logic [STATUS_W-1:0] ST_NOT_IMPL     = 10'd501;
    localparam logic [STATUS_W-1:0] ST_BAD_VERSION  = 10'd505;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_THRESHOLD = 2'd1;

    localparam logic [CFG_DATA_W-1:0] MAX_RETRIES_RST        = 8'd5;
    localparam logic [CFG_DATA_W-1:0] FALLBACK_THRESHOLD_RST = 8'd4;

    typedef enum logic [1:0] {
        ACT_RETRY      = 2'd0,
        ACT_DONE_OK    = 2'd1,
        ACT_DONE_FATAL = 2'd2,
        ACT_EXHAUSTED  = 2'd3
    } action_t;

    typedef struct packed {
        logic [COUNT_W-1:0] attempt_count;
        logic [COUNT_W-1:0] link_error_count;
        logic               proxy_bypassed;
    } state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] attempts_used;
        logic               keep_direct;
        logic               restore_proxy;
        logic               bypass_proxy;
        logic [WAIT_W-1:0]  wait_ms;
        action_t            action;
    } result_t;

endpackage

/* rtl/rbc_decide.sv */
// Per-beat decision logic: classify the status, pick the wait, update the state.
// Depends on rbc_pkg.
module rbc_decide #(
    parameter int BASE_DELAY_MS = rbc_pkg::DEF_BASE_DELAY_MS,
    parameter int MAX_SHIFT     = rbc_pkg::DEF_MAX_SHIFT
) (
    input  logic [rbc_pkg::STATUS_W-1:0]   status,
    input  logic                           transport_error,
    input  logic [rbc_pkg::DELAY_W-1:0]    retry_after_s,
    input  logic [rbc_pkg::CFG_DATA_W-1:0] max_retries,
    input  logic [rbc_pkg::CFG_DATA_W-1:0] fallback_threshold,
    input  rbc_pkg::state_t                st,
    output rbc_pkg::state_t                st_next,
    output rbc_pkg::result_t               res
);

    localparam int BASE_W  = $clog2(BASE_DELAY_MS + 1);
    localparam int SHIFT_W = $clog2(MAX_SHIFT + 1);
    localparam int PROD_W  = BASE_W + MAX_SHIFT;
    localparam int EXT_W   = (PROD_W > rbc_pkg::WAIT_W) ? PROD_W : rbc_pkg::WAIT_W;

    logic [rbc_pkg::COUNT_W-1:0] link_inc;
    logic                        success;
    logic                        retryable;
    logic [EXT_W-1:0]            shifted;
    logic [rbc_pkg::WAIT_W-1:0]  backoff;
    logic                        bypass_now;

    always_comb
    begin
        link_inc = (transport_error && st.link_error_count != '1)
                 ? st.link_error_count + 1'b1 : st.link_error_count;

        success   = status >= rbc_pkg::ST_SUCCESS_LO
                 && status <= rbc_pkg::ST_SUCCESS_HI;
        retryable = status == rbc_pkg::ST_NONE
                 || (status < rbc_pkg::ST_CLIENT_LO
                     && status != rbc_pkg::ST_NOT_MODIFIED)
                 || status == rbc_pkg::ST_REQ_TIMEOUT
                 || (status >= rbc_pkg::ST_SERVER_LO
                     && status != rbc_pkg::ST_NOT_IMPL
                     && status != rbc_pkg::ST_BAD_VERSION);

        shifted = EXT_W'(BASE_DELAY_MS) << st.attempt_count[SHIFT_W-1:0];
        if (st.attempt_count > rbc_pkg::COUNT_W'(MAX_SHIFT))
        begin
            backoff = rbc_pkg::LONG_WAIT_MS;
        end
        else if (shifted > EXT_W'(rbc_pkg::WAIT_MAX))
        begin
            backoff = rbc_pkg::WAIT_MAX;
        end
        else
        begin
            backoff = shifted[rbc_pkg::WAIT_W-1:0];
        end

        bypass_now = fallback_threshold != '0 && link_inc > fallback_threshold;

        res                = '0;
        res.attempts_used  = st.attempt_count;
        st_next            = '0;

        priority if (success)
        begin
            res.action      = rbc_pkg::ACT_DONE_OK;
            res.keep_direct = st.proxy_bypassed;
        end
        else if (!retryable)
        begin
            res.action        = rbc_pkg::ACT_DONE_FATAL;
            res.restore_proxy = st.proxy_bypassed;
        end
        else if (st.attempt_count >= max_retries)
        begin
            res.action        = rbc_pkg::ACT_EXHAUSTED;
            res.restore_proxy = st.proxy_bypassed;
        end
        else
        begin
            res.action               = rbc_pkg::ACT_RETRY;
            st_next.link_error_count = link_inc;
            st_next.attempt_count    = st.attempt_count;
            st_next.proxy_bypassed   = st.proxy_bypassed | bypass_now;
            priority if (retry_after_s[rbc_pkg::DELAY_W-1])
            begin
                res.wait_ms = '0;
            end
            else if (retry_after_s != '0)
            begin
                res.wait_ms = rbc_pkg::WAIT_W'(retry_after_s[rbc_pkg::DELAY_W-2:0])
                            * rbc_pkg::WAIT_W'(rbc_pkg::MS_PER_S);
            end
            else
            begin
                res.wait_ms = backoff;
                if (st.attempt_count != '1)
                begin
                    st_next.attempt_count = st.attempt_count + 1'b1;
                end
            end
            res.bypass_proxy  = st_next.proxy_bypassed;
            res.attempts_used = st_next.attempt_count;
        end
    end

endmodule

/* rtl/retry_backoff_controller.sv */
// Retry/backoff controller top level: configuration registers, state and output queue.
// Depends on rbc_pkg and rbc_decide.
//
// One attempt outcome is taken per clock cycle while s_axis_tready is high; its
// result is registered into the output queue as the beat is accepted. Throughput is
// one beat per cycle while the queue has room, set by the combinational decision
// logic that updates the attempt, transport-error and bypass state as each beat is
// accepted. Results go into a two-entry output queue, so the slave side keeps
// accepting while one result waits; s_axis_tready drops only when two results are
// waiting. Configuration writes are accepted every cycle and should be issued only
// while no beat is in flight.
module retry_backoff_controller #(
    parameter int BASE_DELAY_MS = rbc_pkg::DEF_BASE_DELAY_MS,
    parameter int MAX_SHIFT     = rbc_pkg::DEF_MAX_SHIFT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [9:0] status, [10] transport_error, [26:11] retry_after_s, [31:27] zero
    input  logic [rbc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] action, [26:2] wait_ms, [27] bypass_proxy, [28] restore_proxy,
    // [29] keep_direct, [37:30] attempts_used, [39:38] zero
    output logic [rbc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int RES_W = $bits(rbc_pkg::result_t);

    logic [rbc_pkg::CFG_DATA_W-1:0] max_retries_reg;
    logic [rbc_pkg::CFG_DATA_W-1:0] fallback_threshold_reg;
    rbc_pkg::state_t                state_reg;
    rbc_pkg::state_t                state_next;
    rbc_pkg::result_t               res;
    rbc_pkg::result_t               head_reg;
    rbc_pkg::result_t               head_next;
    rbc_pkg::result_t               tail_reg;
    rbc_pkg::result_t               tail_next;
    logic [1:0]                     count_reg;
    logic [1:0]                     count_next;
    logic                           push;
    logic                           pop;

    rbc_decide #(
        .BASE_DELAY_MS (BASE_DELAY_MS),
        .MAX_SHIFT     (MAX_SHIFT)
    ) u_decide (
        .status             (s_axis_tdata[9:0]),
        .transport_error    (s_axis_tdata[10]),
        .retry_after_s      (s_axis_tdata[26:11]),
        .max_retries        (max_retries_reg),
        .fallback_threshold (fallback_threshold_reg),
        .st                 (state_reg),
        .st_next            (state_next),
        .res                (res)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = count_reg != 2'd2;
    assign m_axis_tvalid = count_reg != 2'd0;
    assign m_axis_tdata  = {(rbc_pkg::OUT_DATA_W - RES_W)'(0), head_reg};
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = tail_reg;
        end
        if (push)
        begin
            if (count_reg == 2'd0 || (count_reg == 2'd1 && pop))
            begin
                head_next = res;
            end
            else
            begin
                tail_next = res;
            end
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retries_reg        <= rbc_pkg::MAX_RETRIES_RST;
            fallback_threshold_reg <= rbc_pkg::FALLBACK_THRESHOLD_RST;
            state_reg              <= '0;
            count_reg              <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    rbc_pkg::REG_MAX_RETRIES:        max_retries_reg <= cfg_data;
                    rbc_pkg::REG_FALLBACK_THRESHOLD: fallback_threshold_reg <= cfg_data;
                    default:                         ;
                endcase
            end
            if (push)
            begin
                state_reg <= state_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

/* rtl/rbc_checker.sv */
// Port-level checks of the retry/backoff controller and the bind that attaches them.
// Depends on rbc_pkg and retry_backoff_controller.
module rbc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [rbc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic [1:0] act;
    assign act = m_axis_tdata[1:0];

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    a_done_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && act != rbc_pkg::ACT_RETRY |->
            m_axis_tdata[26:2] == '0 && !m_axis_tdata[27])
        else $error("final outcome carries a wait or bypass");

    a_keep_on_success: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[29] |->
            act == rbc_pkg::ACT_DONE_OK && !m_axis_tdata[28])
        else $error("keep_direct outside a success");

    a_restore_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[28] |->
            act == rbc_pkg::ACT_DONE_FATAL || act == rbc_pkg::ACT_EXHAUSTED)
        else $error("restore_proxy outside a failed final outcome");

endmodule

bind retry_backoff_controller rbc_checker u_rbc_checker (.*);

/* sim/retry_backoff_controller_tb.sv */
`timescale 1ns / 1ps
// Testbench for retry_backoff_controller: directed and random attempt outcomes,
// each result beat checked field by field against an in-bench decision predictor.
// Depends on rbc_pkg and the retry_backoff_controller RTL.
module retry_backoff_controller_tb;

    localparam logic [rbc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [rbc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int BASE_MS     = rbc_pkg::DEF_BASE_DELAY_MS;
    localparam int SHIFT_LIMIT = rbc_pkg::DEF_MAX_SHIFT;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [rbc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [rbc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [rbc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rbc_pkg::CFG_DATA_W-1:0] cfg_data;

    logic [rbc_pkg::COUNT_W-1:0] max_retries_q;
    logic [rbc_pkg::COUNT_W-1:0] threshold_q;
    logic [rbc_pkg::COUNT_W-1:0] attempts_q;
    logic [rbc_pkg::COUNT_W-1:0] link_errs_q;
    logic                        bypassed_q;

    rbc_pkg::result_t expected_decisions[$];
    int               error_count;
    bit               tx_burst;
    bit               rx_burst;

    retry_backoff_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic is_success(input logic [rbc_pkg::STATUS_W-1:0] s);
        return (s >= rbc_pkg::ST_SUCCESS_LO) && (s <= rbc_pkg::ST_SUCCESS_HI);
    endfunction

    function automatic logic is_retryable_status(input logic [rbc_pkg::STATUS_W-1:0] s);
        if (s == rbc_pkg::ST_NONE)
            return 1'b1;
        if (s < rbc_pkg::ST_CLIENT_LO)
            return s != rbc_pkg::ST_NOT_MODIFIED;
        if (s == rbc_pkg::ST_REQ_TIMEOUT)
            return 1'b1;
        if (s >= rbc_pkg::ST_SERVER_LO)
            return (s != rbc_pkg::ST_NOT_IMPL) && (s != rbc_pkg::ST_BAD_VERSION);
        return 1'b0;
    endfunction

    function automatic void predict_decision(
        input logic [rbc_pkg::STATUS_W-1:0]       status,
        input logic                               terr,
        input logic signed [rbc_pkg::DELAY_W-1:0] delay);
        rbc_pkg::result_t r;
        logic [63:0]      wait_v;
        r = '0;
        wait_v = '0;
        r.action = rbc_pkg::ACT_RETRY;
        if (terr && link_errs_q != '1)
            link_errs_q++;
        if (is_success(status))
        begin
            r.action = rbc_pkg::ACT_DONE_OK;
            r.keep_direct = bypassed_q;
        end
        else if (!is_retryable_status(status))
        begin
            r.action = rbc_pkg::ACT_DONE_FATAL;
            r.restore_proxy = bypassed_q;
        end
        else if (attempts_q >= max_retries_q)
        begin
            r.action = rbc_pkg::ACT_EXHAUSTED;
            r.restore_proxy = bypassed_q;
        end
        if (r.action != rbc_pkg::ACT_RETRY)
        begin
            r.attempts_used = attempts_q;
            attempts_q = '0;
            link_errs_q = '0;
            bypassed_q = 1'b0;
        end
        else
        begin
            if (delay > 0)
                wait_v = 64'(delay) * 64'd1000;
            else if (delay == 0)
            begin
                if (attempts_q > SHIFT_LIMIT)
                    wait_v = 64'(rbc_pkg::LONG_WAIT_MS);
                else
                    wait_v = 64'(BASE_MS) << attempts_q;
                if (attempts_q != '1)
                    attempts_q++;
            end
            if (wait_v > 64'(rbc_pkg::WAIT_MAX))
                wait_v = 64'(rbc_pkg::WAIT_MAX);
            if (threshold_q != '0 && link_errs_q > threshold_q)
                bypassed_q = 1'b1;
            r.wait_ms = wait_v[rbc_pkg::WAIT_W-1:0];
            r.bypass_proxy = bypassed_q;
            r.attempts_used = attempts_q;
        end
        expected_decisions.insert(expected_decisions.size(), r);
    endfunction

    function automatic void compare_decision(input rbc_pkg::result_t exp_r,
                                             input rbc_pkg::result_t got);
        if (got.action !== exp_r.action)
        begin
            $error("action: expected %0d, got %0d", exp_r.action, got.action);
            error_count++;
        end
        if (got.wait_ms !== exp_r.wait_ms)
        begin
            $error("wait_ms: expected %0d, got %0d", exp_r.wait_ms, got.wait_ms);
            error_count++;
        end
        if (got.bypass_proxy !== exp_r.bypass_proxy)
        begin
            $error("bypass_proxy: expected %0d, got %0d",
                   exp_r.bypass_proxy, got.bypass_proxy);
            error_count++;
        end
        if (got.restore_proxy !== exp_r.restore_proxy)
        begin
            $error("restore_proxy: expected %0d, got %0d",
                   exp_r.restore_proxy, got.restore_proxy);
            error_count++;
        end
        if (got.keep_direct !== exp_r.keep_direct)
        begin
            $error("keep_direct: expected %0d, got %0d",
                   exp_r.keep_direct, got.keep_direct);
            error_count++;
        end
        if (got.attempts_used !== exp_r.attempts_used)
        begin
            $error("attempts_used: expected %0d, got %0d",
                   exp_r.attempts_used, got.attempts_used);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_decisions.size() == 0)
            begin
                $error("result beat with nothing expected: %h", m_axis_tdata);
                error_count++;
            end
            else
                compare_decision(expected_decisions.pop_front(),
                    rbc_pkg::result_t'(m_axis_tdata[$bits(rbc_pkg::result_t)-1:0]));
        end
    end

    // hold the result side's tready low at random before each beat, except in rx_burst runs
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic send_outcome(input logic [rbc_pkg::STATUS_W-1:0] status,
                                input logic terr,
                                input logic signed [rbc_pkg::DELAY_W-1:0] delay);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tdata  <= rbc_pkg::IN_DATA_W'({delay, terr, status});
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
        predict_decision(status, terr, delay);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_decisions.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rbc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rbc_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        if (idx == rbc_pkg::REG_MAX_RETRIES)
            max_retries_q = value;
        else if (idx == rbc_pkg::REG_FALLBACK_THRESHOLD)
            threshold_q = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [rbc_pkg::DELAY_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return '0;
            5, 6:          return rbc_pkg::DELAY_W'($urandom_range(1, 32767));
            7:             return rbc_pkg::DELAY_W'(0 - $urandom_range(1, 32768));
            8:             return rbc_pkg::DELAY_W'($urandom());
            default:       return $urandom_range(0, 1) ? rbc_pkg::DELAY_W'(16'h7FFF)
                                                       : rbc_pkg::DELAY_W'(16'h8000);
        endcase
    endfunction

    function automatic logic [rbc_pkg::STATUS_W-1:0] pick_retryable_status();
        logic [rbc_pkg::STATUS_W-1:0] s;
        if ($urandom_range(0, 7) == 0)
            return rbc_pkg::ST_NONE;
        do s = rbc_pkg::STATUS_W'($urandom_range(0, 1023));
        while (!is_retryable_status(s) || is_success(s));
        return s;
    endfunction

    function automatic logic [rbc_pkg::STATUS_W-1:0] pick_fatal_status();
        logic [rbc_pkg::STATUS_W-1:0] s;
        case ($urandom_range(0, 5))
            0: return rbc_pkg::ST_NOT_MODIFIED;
            1: return rbc_pkg::ST_NOT_IMPL;
            2: return rbc_pkg::ST_BAD_VERSION;
            default:
            begin
                do s = rbc_pkg::STATUS_W'($urandom_range(400, 499));
                while (s == rbc_pkg::ST_REQ_TIMEOUT);
                return s;
            end
        endcase
    endfunction

    // each session: a run of mostly retryable outcomes, then a closing outcome
    task automatic run_sessions(input int n_items);
        int                           sent;
        int                           n_fail;
        logic [rbc_pkg::STATUS_W-1:0] s;
        sent = 0;
        while (sent < n_items)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            n_fail = $urandom_range(0, 15);
            repeat (n_fail)
            begin
                if ($urandom_range(0, 9) == 0)
                    s = rbc_pkg::STATUS_W'($urandom_range(0, 1023));
                else
                    s = pick_retryable_status();
                send_outcome(s, 1'($urandom_range(0, 1)), pick_delay());
                sent++;
            end
            case ($urandom_range(0, 3))
                0:       s = rbc_pkg::STATUS_W'($urandom_range(rbc_pkg::ST_SUCCESS_LO,
                                                               rbc_pkg::ST_SUCCESS_HI));
                1:       s = pick_fatal_status();
                2:       s = pick_retryable_status();
                default: s = rbc_pkg::STATUS_W'($urandom_range(0, 1023));
            endcase
            send_outcome(s, 1'($urandom_range(0, 1)), pick_delay());
            sent++;
        end
    endtask

    task automatic test_classification();
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        send_outcome(rbc_pkg::ST_NONE, 1'b1, 16'sd0);
        send_outcome(rbc_pkg::ST_SERVER_LO + 10'd3, 1'b1, 16'sh7FFF);
        send_outcome(rbc_pkg::ST_REQ_TIMEOUT, 1'b1, 16'sh8000);
        send_outcome(rbc_pkg::ST_SERVER_LO, 1'b1, -16'sd1);
        send_outcome(10'd1023, 1'b1, 16'sd1);
        send_outcome(rbc_pkg::ST_SUCCESS_LO, 1'b0, 16'sd0);
        send_outcome(rbc_pkg::ST_SUCCESS_LO - 10'd1, 1'b0, 16'sd0);
        send_outcome(rbc_pkg::ST_NOT_MODIFIED, 1'b0, 16'sd0);
        send_outcome(rbc_pkg::ST_SUCCESS_HI + 10'd1, 1'b0, 16'sd0);
        send_outcome(rbc_pkg::ST_CLIENT_LO - 10'd1, 1'b0, 16'sd0);
        send_outcome(rbc_pkg::ST_CLIENT_LO, 1'b0, 16'sd0);
        send_outcome(rbc_pkg::ST_SERVER_LO - 10'd1, 1'b0, 16'sd0);
        send_outcome(rbc_pkg::ST_NOT_IMPL, 1'b0, 16'sd0);
        send_outcome(rbc_pkg::ST_BAD_VERSION, 1'b0, 16'sd0);
        send_outcome(rbc_pkg::ST_SUCCESS_HI, 1'b1, 16'sd0);
        // walk the backoff up to exhaustion with default limits
        send_outcome(10'd1000, 1'b0, 16'sd0);
        send_outcome(10'd999, 1'b0, 16'sd0);
        send_outcome(rbc_pkg::ST_SERVER_LO + 10'd2, 1'b0, 16'sd0);
        send_outcome(rbc_pkg::ST_SERVER_LO + 10'd4, 1'b0, 16'sd0);
        send_outcome(rbc_pkg::ST_SERVER_LO + 10'd6, 1'b0, 16'sd0);
        send_outcome(rbc_pkg::ST_SERVER_LO + 10'd3, 1'b0, 16'sd0);
        repeat (5) send_outcome(rbc_pkg::ST_NONE, 1'b1, 16'sd5);
        send_outcome(rbc_pkg::ST_CLIENT_LO + 10'd4, 1'b0, 16'sd0);
    endtask

    task automatic test_random_sessions();
        logic [rbc_pkg::CFG_DATA_W-1:0] retries;
        logic [rbc_pkg::CFG_DATA_W-1:0] thresh;
        for (int i = 0; i < 7; i++)
        begin
            case (i)
                0:       begin retries = 8'd0;   thresh = 8'd0;   end
                1:       begin retries = 8'd255; thresh = 8'd255; end
                2:       begin retries = 8'd1;   thresh = 8'd1;   end
                3:       begin retries = 8'd20;  thresh = 8'd3;   end
                4:       begin retries = 8'd14;  thresh = 8'd0;   end
                5:
                begin
                    retries = rbc_pkg::CFG_DATA_W'($urandom());
                    thresh  = rbc_pkg::CFG_DATA_W'($urandom());
                end
                default:
                begin
                    retries = rbc_pkg::CFG_DATA_W'($urandom_range(0, 16));
                    thresh  = 8'd1;
                end
            endcase
            drain_results();
            write_reg(rbc_pkg::REG_MAX_RETRIES, retries);
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      rbc_pkg::CFG_DATA_W'($urandom()));
            write_reg(rbc_pkg::REG_FALLBACK_THRESHOLD, thresh);
            run_sessions(28);
        end
    endtask

    // one long session: transport errors saturate and the proxy goes direct
    task automatic test_error_saturation();
        logic signed [rbc_pkg::DELAY_W-1:0] delay;
        drain_results();
        write_reg(rbc_pkg::REG_MAX_RETRIES, 8'd255);
        write_reg(rbc_pkg::REG_FALLBACK_THRESHOLD, 8'd254);
        for (int i = 0; i < 270; i++)
        begin
            if (i % 30 == 0)
            begin
                tx_burst = ($urandom_range(0, 2) == 0);
                rx_burst = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 3) == 0)
                delay = '0;
            else
                do delay = pick_delay(); while (delay == 0);
            send_outcome(pick_retryable_status(),
                         (i < 258) ? 1'b1 : 1'($urandom_range(0, 1)), delay);
        end
        send_outcome(pick_fatal_status(), 1'b1, pick_delay());
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = rbc_pkg::REG_MAX_RETRIES;
        cfg_data      = '0;
        error_count   = 0;
        tx_burst      = 1'b0;
        rx_burst      = 1'b0;
        max_retries_q = rbc_pkg::MAX_RETRIES_RST;
        threshold_q   = rbc_pkg::FALLBACK_THRESHOLD_RST;
        attempts_q    = '0;
        link_errs_q   = '0;
        bypassed_q    = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_classification();
        test_random_sessions();
        test_error_saturation();

        drain_results();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
